@@ rtl/core/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// efd_pkg - shared definitions for the escaped frame decoder
// escape codes, event kinds and register map of the byte deframer
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

  localparam logic [7:0] ESC_LEAD    = 8'h55;
  localparam logic [7:0] ESC_START   = 8'h01;
  localparam logic [7:0] ESC_LITERAL = 8'h02;
  localparam logic [7:0] ESC_END     = 8'h03;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUM_W   = 16;

  localparam logic [COUNT_W-1:0] FRAME_LIMIT_RESET = 16'd256;

  // register index of the configuration port
  localparam logic REG_FRAME_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    EV_DATA      = 3'd0,
    EV_START     = 3'd1,
    EV_END_OK    = 3'd2,
    EV_CSUM_FAIL = 3'd3,
    EV_OVERFLOW  = 3'd4,
    EV_EMPTY     = 3'd5
  } event_kind_t;

endpackage

`default_nettype wire

@@ rtl/core/escaped_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_decoder - byte stuffing deframer with additive checksum
// an accepted byte's event is written into the result register in the next cycle
// throughput: one byte per cycle while out_ready holds, set by the single result register stage
// rst (synchronous, active high) clears the escape, count, sum and discard
// state, empties the result register and sets frame_limit to 256
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // received byte channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  // event channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_kind,
  output logic [7:0]       data_value,
  output logic [15:0]      frame_length
);

  localparam int unsigned CW = efd_pkg::COUNT_W;
  localparam int unsigned SW = efd_pkg::SUM_W;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CW-1:0] frame_limit;
  logic          cfg_write;
  logic          cfg_hit;

  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == efd_pkg::REG_FRAME_LIMIT);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= efd_pkg::FRAME_LIMIT_RESET;
    end else if (cfg_write) begin
      frame_limit <= pwdata[CW-1:0];
    end
  end

  // read back, unused address space reads as zero
  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = {{(32-CW){1'b0}}, frame_limit};
    end
  end

  // --------------------------------------------------------------------------
  // deframer state
  // --------------------------------------------------------------------------
  logic          escape_pending, escape_pending_next;
  logic [CW-1:0] byte_count,     byte_count_next;
  logic [SW-1:0] running_sum,    running_sum_next;
  logic [7:0]    last_byte,      last_byte_next;
  logic          discarding,     discarding_next;

  // result of the byte being accepted this cycle
  logic                res_valid;
  efd_pkg::event_kind_t res_kind;
  logic [7:0]          res_data;
  logic [CW-1:0]       res_length;

  logic in_fire;

  // output register parts the two sides: a new byte is taken whenever the
  // held event leaves this cycle or none is held
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // byte that would be stored if this item turns out to be data
  logic [7:0] data_byte;
  logic       is_data;
  logic       is_end;
  logic       is_start;
  logic       csum_ok;

  always_comb begin
    // classify the byte against the escape state
    is_data   = 1'b0;
    is_end    = 1'b0;
    is_start  = 1'b0;
    data_byte = rx_byte;
    escape_pending_next = escape_pending;
    if (!escape_pending) begin
      if (rx_byte == efd_pkg::ESC_LEAD) begin
        escape_pending_next = 1'b1;
      end else begin
        is_data = 1'b1;
      end
    end else begin
      escape_pending_next = 1'b0;
      case (rx_byte)
        efd_pkg::ESC_START:   is_start = 1'b1;
        efd_pkg::ESC_END:     is_end   = 1'b1;
        efd_pkg::ESC_LITERAL: begin
          is_data   = 1'b1;
          data_byte = efd_pkg::ESC_LEAD;
        end
        default:              is_data  = 1'b1;
      endcase
    end

    // checksum: last byte equals low byte of the sum of those before it
    csum_ok = ((running_sum[7:0] - last_byte) == last_byte);

    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    last_byte_next   = last_byte;
    discarding_next  = discarding;
    res_valid        = 1'b0;
    res_kind         = efd_pkg::EV_DATA;
    res_data         = '0;
    res_length       = '0;

    if (is_start) begin
      byte_count_next  = '0;
      running_sum_next = '0;
      last_byte_next   = '0;
      discarding_next  = 1'b0;
      res_valid        = 1'b1;
      res_kind         = efd_pkg::EV_START;
    end else if (is_data && !discarding) begin
      res_valid = 1'b1;
      if (byte_count >= frame_limit) begin
        // frame full: drop everything up to the next start
        discarding_next = 1'b1;
        res_kind        = efd_pkg::EV_OVERFLOW;
      end else begin
        byte_count_next  = byte_count + 1'b1;
        running_sum_next = running_sum + {{(SW-8){1'b0}}, data_byte};
        last_byte_next   = data_byte;
        res_kind         = efd_pkg::EV_DATA;
        res_data         = data_byte;
      end
    end else if (is_end && !discarding) begin
      res_valid        = 1'b1;
      byte_count_next  = '0;
      running_sum_next = '0;
      last_byte_next   = '0;
      if (byte_count == '0) begin
        res_kind = efd_pkg::EV_EMPTY;
      end else begin
        res_kind   = csum_ok ? efd_pkg::EV_END_OK : efd_pkg::EV_CSUM_FAIL;
        res_length = byte_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      byte_count     <= '0;
      running_sum    <= '0;
      last_byte      <= '0;
      discarding     <= 1'b0;
    end else if (in_fire) begin
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      last_byte      <= last_byte_next;
      discarding     <= discarding_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload held while an item waits, loaded only with a new item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_kind   <= res_kind;
      data_value   <= res_data;
      frame_length <= res_length;
    end
  end

`ifndef SYNTHESIS
  // data byte only travels with a data event
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != efd_pkg::EV_DATA) |-> data_value == 8'd0)
    else $error("data_value set on a non-data event");

  // length only travels with a reported frame end
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != efd_pkg::EV_END_OK)
      && (event_kind != efd_pkg::EV_CSUM_FAIL) |-> frame_length == 16'd0)
    else $error("frame_length set on an event that is not a frame end");

  // while discarding, an unescaped ordinary byte yields no event
  assert property (@(posedge clk) disable iff (rst)
    in_fire && discarding && !escape_pending && (rx_byte != efd_pkg::ESC_LEAD)
      |=> !out_valid)
    else $error("event produced while discarding");

  // an escaped start reopens a clean frame
  assert property (@(posedge clk) disable iff (rst)
    in_fire && escape_pending && (rx_byte == efd_pkg::ESC_START)
      |=> (byte_count == '0) && !discarding && out_valid
          && (event_kind == efd_pkg::EV_START))
    else $error("frame start did not clear the frame state");
`endif

endmodule

`default_nettype wire
